@@ hdl/pws_pkg.sv @@
// shared constants, types and lookup tables of the phase waveshaper
package pws_pkg;

  typedef longint unsigned u64_t;

  // lookup table address width and depth
  localparam int TAB_BITS = 10;
  localparam int TAB_N    = 1 << TAB_BITS;

  // divider geometry: numerator, divisor and quotient widths
  localparam int NUM_W    = 32;
  localparam int DEN_W    = 17;
  localparam int DIV_BITS = 16;

  // knob registers: 17 bits, 65536 means one
  localparam int KNOB_W = 17;
  localparam logic [KNOB_W-1:0] KNOB_ONE   = 17'h10000;
  localparam logic [KNOB_W-1:0] KNOB_RESET = 17'h08000;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRI_SYMMETRY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RC_ROLLOFF   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_RATE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAP_SLOPE   = 2'd3;

  // where a phase falls on the trapezoid / raised cosine
  typedef enum logic [1:0] {
    RGN_LOW,
    RGN_RISE,
    RGN_HIGH,
    RGN_FALL
  } region_t;

  // edge lane divider job
  typedef struct packed {
    region_t            rgn;
    logic [NUM_W-1:0]   num;
    logic [DEN_W-1:0]   den;
  } edge_t;

  // per-word control and scaling data that rides alongside the lanes
  typedef struct packed {
    logic               valid;
    logic               last;
    logic               half;
    logic               tri_lo;
    logic               dec_cap;
    region_t            trap_rgn;
    region_t            rc_rgn;
    logic signed [15:0] gain;
    logic signed [15:0] level_offset;
    logic signed [15:0] outer_gain;
  } side_t;

  typedef logic signed [15:0] cos_tab_t [TAB_N];
  typedef logic [16:0]        exp_tab_t [TAB_N];

  // truncating unsigned division by shift and subtract, for table building
  function automatic u64_t udiv64(input u64_t n, input u64_t d);
    u64_t q;
    logic [64:0] rem;
    q = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // cos(pi*i/N) in Q1.15 from a Q30 series
  function automatic cos_tab_t cos_build();
    cos_tab_t tab;
    u64_t j;
    u64_t th;
    u64_t x2;
    u64_t term;
    u64_t c;
    longint sum;
    logic neg;
    for (int i = 0; i < TAB_N; i++) begin
      j = u64_t'(i);
      neg = 1'b0;
      if (i > (TAB_N >> 1)) begin
        j = u64_t'(TAB_N - i);
        neg = 1'b1;
      end
      th = (u64_t'(64'd3373259426) * j) >> TAB_BITS;
      x2 = (th * th) >> 30;
      term = u64_t'(1) << 30;
      sum = longint'(1) << 30;
      for (int k = 1; k <= 10; k++) begin
        term = udiv64((term * x2) >> 30, u64_t'((2 * k - 1) * (2 * k)));
        if ((k % 2) == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      c = (u64_t'(sum) + u64_t'(16384)) >> 15;
      if (c > u64_t'(32767)) c = u64_t'(32767);
      tab[i] = neg ? -16'(c) : 16'(c);
    end
    return tab;
  endfunction

  // exp(-8*i/N) in Q16 from a Q30 series and four squarings
  function automatic exp_tab_t exp_build();
    exp_tab_t tab;
    u64_t u;
    u64_t term;
    u64_t e;
    longint sum;
    for (int i = 0; i < TAB_N; i++) begin
      u = u64_t'(i) << (29 - TAB_BITS);
      term = u64_t'(1) << 30;
      sum = longint'(1) << 30;
      for (int k = 1; k <= 12; k++) begin
        term = udiv64((term * u) >> 30, u64_t'(k));
        if ((k % 2) == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      e = u64_t'(sum);
      for (int k = 0; k < 4; k++) e = (e * e + (u64_t'(1) << 29)) >> 30;
      tab[i] = 17'((e + u64_t'(8192)) >> 14);
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_TAB = cos_build();
  localparam exp_tab_t EXP_TAB = exp_build();

endpackage

@@ hdl/pws_div.sv @@
// pipelined restoring divider, one quotient bit per stage
module pws_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [pws_pkg::NUM_W-1:0]     num,
  input  logic [pws_pkg::DEN_W-1:0]     den,
  output logic [pws_pkg::DIV_BITS-1:0]  quo
);

  logic [pws_pkg::NUM_W-1:0]    rem_r [pws_pkg::DIV_BITS];
  logic [pws_pkg::DEN_W-1:0]    den_r [pws_pkg::DIV_BITS];
  logic [pws_pkg::DIV_BITS-1:0] quo_r [pws_pkg::DIV_BITS];
  logic [pws_pkg::NUM_W-1:0]    rem_nxt [pws_pkg::DIV_BITS];
  logic [pws_pkg::DIV_BITS-1:0] quo_nxt [pws_pkg::DIV_BITS];

  // each stage tries the divisor shifted to its own quotient bit
  always_comb begin
    logic [pws_pkg::NUM_W:0]      dsh;
    logic [pws_pkg::NUM_W-1:0]    prem;
    logic [pws_pkg::DEN_W-1:0]    pden;
    logic [pws_pkg::DIV_BITS-1:0] pquo;
    for (int i = 0; i < pws_pkg::DIV_BITS; i++) begin
      if (i == 0) begin
        prem = num;
        pden = den;
        pquo = '0;
      end else begin
        prem = rem_r[i-1];
        pden = den_r[i-1];
        pquo = quo_r[i-1];
      end
      dsh = (pws_pkg::NUM_W+1)'(pden) << (pws_pkg::DIV_BITS - 1 - i);
      rem_nxt[i] = prem;
      quo_nxt[i] = pquo;
      if ({1'b0, prem} >= dsh) begin
        rem_nxt[i] = prem - dsh[pws_pkg::NUM_W-1:0];
        quo_nxt[i][pws_pkg::DIV_BITS-1-i] = 1'b1;
      end
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= den;
      for (int i = 0; i < pws_pkg::DIV_BITS; i++) begin
        rem_r[i] <= rem_nxt[i];
        quo_r[i] <= quo_nxt[i];
      end
      for (int i = 1; i < pws_pkg::DIV_BITS; i++) den_r[i] <= den_r[i-1];
    end
  end

  assign quo = quo_r[pws_pkg::DIV_BITS-1];

endmodule

@@ hdl/pws_scale.sv @@
// three-stage gain, offset, outer gain, rounding and saturation for one shape
module pws_scale (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] shape,
  input  logic signed [15:0] gain,
  input  logic signed [15:0] level_offset,
  input  logic signed [15:0] outer_gain,
  output logic signed [15:0] y
);

  logic signed [31:0] m1_r;
  logic signed [15:0] off_r;
  logic signed [15:0] og_r;
  logic signed [49:0] m2_r;
  logic signed [15:0] y_r;
  logic signed [33:0] inner;
  logic signed [49:0] rnd;
  logic signed [20:0] y21;
  logic signed [15:0] y_nxt;

  // offset joins in Q17 units, then the outer gain
  assign inner = 34'(m1_r) + (34'(off_r) <<< 17);

  // round half up and saturate
  always_comb begin
    rnd = m2_r + 50'sd268435456;
    y21 = rnd[49:29];
    if (y21 > 21'sd32767) y_nxt = 16'sd32767;
    else if (y21 < -21'sd32768) y_nxt = -16'sd32768;
    else y_nxt = y21[15:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r  <= 32'(shape) * 32'(gain);
      off_r <= level_offset;
      og_r  <= outer_gain;
      m2_r  <= 50'(inner) * 50'(og_r);
      y_r   <= y_nxt;
    end
  end

  assign y = y_r;

endmodule

@@ hdl/phase_waveshaper_four_shapes.sv @@
// top level of the four-shape phase waveshaper
// Takes one phase word per cycle and returns one word of four Q5.10 voltages
// (triangle, raised cosine, trapezoid, exponential) per input word, in order.
// Throughput is one word per clock; each word passes four front stages for knob decode
// and exponential table reads, the 16-stage dividers that each shape lane runs through,
// two shaping stages and three scaling stages. The whole pipeline holds while a
// finished word waits on out_tready.
// Knob registers are written through the cfg port and must only change while
// the pipeline is empty.
module phase_waveshaper_four_shapes (
  input  logic                             clk,
  input  logic                             rst_n,
  // phase [15:0], gain [31:16], level_offset [47:32], outer_gain [63:48]
  input  logic [63:0]                      in_tdata,
  input  logic                             in_tlast,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tri_out [15:0], rc_out [31:16], trap_out [47:32], decay_out [63:48]
  output logic [63:0]                      out_tdata,
  output logic                             out_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pws_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pws_pkg::KNOB_W-1:0]       cfg_data
);

  logic en;

  // knob registers
  logic [pws_pkg::KNOB_W-1:0] tri_sym_r;
  logic [pws_pkg::KNOB_W-1:0] rc_roll_r;
  logic [pws_pkg::KNOB_W-1:0] decay_rate_r;
  logic [pws_pkg::KNOB_W-1:0] trap_slope_r;

  // stage 1: captured input
  logic               v1_r;
  logic               last1_r;
  logic [15:0]        ph1_r;
  logic signed [15:0] g1_r;
  logic signed [15:0] off1_r;
  logic signed [15:0] og1_r;

  // stage 2..4 lanes
  pws_pkg::side_t            side2_r, side3_r, side4_r;
  logic [pws_pkg::NUM_W-1:0] tri_num2_r, tri_num3_r, tri_num4_r;
  logic [pws_pkg::DEN_W-1:0] tri_den2_r, tri_den3_r, tri_den4_r;
  pws_pkg::edge_t            trap2_r, trap3_r, trap4_r;
  pws_pkg::edge_t            rc2_r, rc3_r, rc4_r;
  logic [32:0]               qr2_r;
  logic [pws_pkg::TAB_BITS-1:0] oidx2_r;
  logic [16:0]               e3_r;
  logic [16:0]               o3_r;
  logic [pws_pkg::NUM_W-1:0] dec_num4_r;
  logic [pws_pkg::DEN_W-1:0] dec_den4_r;

  // stage 2 comb
  logic [pws_pkg::KNOB_W-1:0] kt, kr, kd, kp;
  logic                       tri_lo;
  logic [pws_pkg::NUM_W-1:0]  tri_num_nxt;
  logic [pws_pkg::DEN_W-1:0]  tri_den_nxt;
  logic [17:0]                r_nxt;
  logic [17+pws_pkg::TAB_BITS:0] r_wide;
  pws_pkg::side_t             side2_nxt;

  // stage 4 comb
  logic [16:0]               dec_den_nxt;
  logic [16:0]               dec_diff;
  logic                      dec_cap;
  pws_pkg::side_t            side4_nxt;

  // divider outputs and side delay
  logic [pws_pkg::DIV_BITS-1:0] tri_q, trap_q, rc_q, dec_q;
  pws_pkg::side_t            sd_r [pws_pkg::DIV_BITS];
  pws_pkg::side_t            sdo;

  // shaping stages
  pws_pkg::side_t            side_p1_r, side_p2_r;
  logic signed [15:0]        tri_p1_r, trap_p1_r, dec_p1_r, cos_p1_r;
  logic signed [15:0]        tri_p2_r, trap_p2_r, dec_p2_r, rc_p2_r;
  logic signed [15:0]        tri_nxt, trap_nxt, dec_nxt, rc_nxt;
  logic [16:0]               dec_f;

  // scaling stage control
  logic va_r, vb_r, out_valid_r;
  logic la_r, lb_r, out_last_r;
  logic signed [15:0] y_tri, y_rc, y_trap, y_dec;

  // knob above one acts as one
  function automatic logic [pws_pkg::KNOB_W-1:0] knob(input logic [pws_pkg::KNOB_W-1:0] v);
    return (v > pws_pkg::KNOB_ONE) ? pws_pkg::KNOB_ONE : v;
  endfunction

  // clamp a shape value that may reach +1.0
  function automatic logic signed [15:0] clamp_hi(input logic signed [17:0] x);
    return (x > 18'sd32767) ? 16'sd32767 : x[15:0];
  endfunction

  // locate a phase on the rising and falling edges and set up the edge division
  function automatic pws_pkg::edge_t edge_prep(input logic [15:0] ph,
                                               input logic [pws_pkg::KNOB_W-1:0] k,
                                               input logic cosine);
    pws_pkg::edge_t res;
    logic [16:0] w;
    logic [19:0] p4, ll, lr, rl, rr, d;
    logic [16:0] dd;
    w  = pws_pkg::KNOB_ONE - k;
    p4 = {2'b00, ph, 2'b00};
    ll = 20'(k);
    lr = 20'd65536 + 20'(w);
    rl = 20'd196608 - 20'(w);
    rr = 20'd196608 + 20'(w);
    d  = '0;
    if (p4 < ll) res.rgn = pws_pkg::RGN_LOW;
    else if (p4 < lr) begin
      res.rgn = pws_pkg::RGN_RISE;
      d = p4 - ll;
    end else if (p4 < rl) res.rgn = pws_pkg::RGN_HIGH;
    else if (p4 < rr) begin
      res.rgn = pws_pkg::RGN_FALL;
      d = p4 - rl;
    end else res.rgn = pws_pkg::RGN_LOW;
    dd = d[16:0];
    res.num = cosine ? (pws_pkg::NUM_W'(dd) << (pws_pkg::TAB_BITS - 1))
                     : (pws_pkg::NUM_W'(dd) << 15);
    res.den = (res.rgn == pws_pkg::RGN_RISE || res.rgn == pws_pkg::RGN_FALL) ? w : 17'd1;
    return res;
  endfunction

  // whole pipeline advances unless a finished word is held
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  // knob register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tri_sym_r    <= pws_pkg::KNOB_RESET;
      rc_roll_r    <= pws_pkg::KNOB_RESET;
      decay_rate_r <= pws_pkg::KNOB_RESET;
      trap_slope_r <= pws_pkg::KNOB_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pws_pkg::CFG_TRI_SYMMETRY: tri_sym_r    <= cfg_data;
        pws_pkg::CFG_RC_ROLLOFF:   rc_roll_r    <= cfg_data;
        pws_pkg::CFG_DECAY_RATE:   decay_rate_r <= cfg_data;
        pws_pkg::CFG_TRAP_SLOPE:   trap_slope_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 2 setup: triangle division, edge regions, exponential argument
  always_comb begin
    kt = knob(tri_sym_r);
    kr = knob(rc_roll_r);
    kd = knob(decay_rate_r);
    kp = knob(trap_slope_r);
    tri_lo = {1'b0, ph1_r} < kt;
    if (tri_lo) begin
      tri_num_nxt = {ph1_r, 16'h0000};
      tri_den_nxt = kt;
    end else begin
      tri_num_nxt = {16'(17'({1'b0, ph1_r}) - kt), 16'h0000};
      tri_den_nxt = pws_pkg::KNOB_ONE - kt;
    end
    r_nxt  = 18'd65536 + {kd, 1'b0};
    r_wide = {r_nxt, {pws_pkg::TAB_BITS{1'b0}}};
    side2_nxt = '{valid: v1_r, last: last1_r, half: ph1_r[15], tri_lo: tri_lo,
                  dec_cap: 1'b0, trap_rgn: pws_pkg::RGN_LOW, rc_rgn: pws_pkg::RGN_LOW,
                  gain: g1_r, level_offset: off1_r, outer_gain: og1_r};
  end

  // exponential lane finish: f is capped at one when e-o reaches the span
  always_comb begin
    dec_den_nxt = 17'h10000 - o3_r;
    if (dec_den_nxt == 17'd0) dec_den_nxt = 17'd1;
    dec_diff = (e3_r > o3_r) ? (e3_r - o3_r) : 17'd0;
    dec_cap  = (e3_r > o3_r) && (dec_diff >= dec_den_nxt);
    side4_nxt = side3_r;
    side4_nxt.dec_cap = dec_cap;
  end

  // front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      side2_r.valid <= 1'b0;
      side3_r.valid <= 1'b0;
      side4_r.valid <= 1'b0;
    end else if (en) begin
      v1_r    <= in_tvalid;
      side2_r <= side2_nxt;
      side3_r <= side2_r;
      side4_r <= side4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      last1_r <= in_tlast;
      ph1_r   <= in_tdata[15:0];
      g1_r    <= in_tdata[31:16];
      off1_r  <= in_tdata[47:32];
      og1_r   <= in_tdata[63:48];

      tri_num2_r <= tri_num_nxt;
      tri_den2_r <= tri_den_nxt;
      trap2_r    <= edge_prep(ph1_r, kp, 1'b0);
      rc2_r      <= edge_prep(ph1_r, kr, 1'b1);
      qr2_r      <= 33'(ph1_r[14:0]) * 33'(r_nxt);
      oidx2_r    <= r_wide[17+pws_pkg::TAB_BITS -: pws_pkg::TAB_BITS];

      tri_num3_r <= tri_num2_r;
      tri_den3_r <= tri_den2_r;
      trap3_r    <= trap2_r;
      rc3_r      <= rc2_r;
      e3_r       <= pws_pkg::EXP_TAB[qr2_r[32 -: pws_pkg::TAB_BITS]];
      o3_r       <= pws_pkg::EXP_TAB[oidx2_r];

      tri_num4_r <= tri_num3_r;
      tri_den4_r <= tri_den3_r;
      trap4_r    <= trap3_r;
      rc4_r      <= rc3_r;
      dec_num4_r <= {dec_diff, 15'h0000};
      dec_den4_r <= dec_den_nxt;
    end
  end

  // four division lanes
  pws_div u_div_tri (.clk(clk), .en(en), .num(tri_num4_r), .den(tri_den4_r), .quo(tri_q));
  pws_div u_div_trap (.clk(clk), .en(en), .num(trap4_r.num), .den(trap4_r.den),
                      .quo(trap_q));
  pws_div u_div_rc (.clk(clk), .en(en), .num(rc4_r.num), .den(rc4_r.den), .quo(rc_q));
  pws_div u_div_dec (.clk(clk), .en(en), .num(dec_num4_r), .den(dec_den4_r), .quo(dec_q));

  // side data delayed to match the dividers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pws_pkg::DIV_BITS; i++) sd_r[i].valid <= 1'b0;
    end else if (en) begin
      sd_r[0] <= '{valid: side4_r.valid, last: side4_r.last, half: side4_r.half,
                   tri_lo: side4_r.tri_lo, dec_cap: side4_r.dec_cap,
                   trap_rgn: trap4_r.rgn, rc_rgn: rc4_r.rgn, gain: side4_r.gain,
                   level_offset: side4_r.level_offset, outer_gain: side4_r.outer_gain};
      for (int i = 1; i < pws_pkg::DIV_BITS; i++) sd_r[i] <= sd_r[i-1];
    end
  end

  assign sdo = sd_r[pws_pkg::DIV_BITS-1];

  // shape forming from the quotients
  always_comb begin
    if (sdo.tri_lo) tri_nxt = clamp_hi(18'(tri_q) - 18'sd32768);
    else tri_nxt = clamp_hi(18'sd32768 - 18'(tri_q));

    unique case (sdo.trap_rgn)
      pws_pkg::RGN_RISE: trap_nxt = clamp_hi(18'(trap_q) - 18'sd32768);
      pws_pkg::RGN_HIGH: trap_nxt = 16'sd32767;
      pws_pkg::RGN_FALL: trap_nxt = clamp_hi(18'sd32768 - 18'(trap_q));
      default:           trap_nxt = -16'sd32768;
    endcase

    dec_f = sdo.dec_cap ? 17'h08000 : {1'b0, dec_q};
    if (sdo.half) dec_nxt = clamp_hi(18'({dec_f, 1'b0}) - 18'sd32768);
    else dec_nxt = clamp_hi(18'sd32768 - 18'({dec_f, 1'b0}));

    unique case (side_p1_r.rc_rgn)
      pws_pkg::RGN_RISE: rc_nxt = -cos_p1_r;
      pws_pkg::RGN_HIGH: rc_nxt = 16'sd32767;
      pws_pkg::RGN_FALL: rc_nxt = cos_p1_r;
      default:           rc_nxt = -16'sd32768;
    endcase
  end

  // shaping stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_p1_r.valid <= 1'b0;
      side_p2_r.valid <= 1'b0;
    end else if (en) begin
      side_p1_r <= sdo;
      side_p2_r <= side_p1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tri_p1_r  <= tri_nxt;
      trap_p1_r <= trap_nxt;
      dec_p1_r  <= dec_nxt;
      cos_p1_r  <= pws_pkg::COS_TAB[rc_q[pws_pkg::TAB_BITS-1:0]];
      tri_p2_r  <= tri_p1_r;
      trap_p2_r <= trap_p1_r;
      dec_p2_r  <= dec_p1_r;
      rc_p2_r   <= rc_nxt;
    end
  end

  // scaling lanes
  pws_scale u_scale_tri (.clk(clk), .en(en), .shape(tri_p2_r), .gain(side_p2_r.gain),
    .level_offset(side_p2_r.level_offset), .outer_gain(side_p2_r.outer_gain), .y(y_tri));
  pws_scale u_scale_rc (.clk(clk), .en(en), .shape(rc_p2_r), .gain(side_p2_r.gain),
    .level_offset(side_p2_r.level_offset), .outer_gain(side_p2_r.outer_gain), .y(y_rc));
  pws_scale u_scale_trap (.clk(clk), .en(en), .shape(trap_p2_r), .gain(side_p2_r.gain),
    .level_offset(side_p2_r.level_offset), .outer_gain(side_p2_r.outer_gain), .y(y_trap));
  pws_scale u_scale_dec (.clk(clk), .en(en), .shape(dec_p2_r), .gain(side_p2_r.gain),
    .level_offset(side_p2_r.level_offset), .outer_gain(side_p2_r.outer_gain), .y(y_dec));

  // valid and frame mark through the scaling stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      va_r        <= side_p2_r.valid;
      vb_r        <= va_r;
      out_valid_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      la_r       <= side_p2_r.last;
      lb_r       <= la_r;
      out_last_r <= lb_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {y_dec, y_trap, y_rc, y_tri};

endmodule
